// ----- rtl/ptq_pkg.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ptq_pkg - shared types and codes for the priority ticket queue
// Action and status codes, class count, parameter defaults and the cell
// status bundle.
// ---------------------------------------------------------------------------
package ptq_pkg;

    localparam int NUM_CLASSES       = 4;
    localparam int CLASS_W           = 2;
    localparam int FIELD_NUMBER_W    = 16;
    localparam int CLASS_DEPTH_DEF   = 16;
    localparam int NUMBER_BITS_DEF   = 16;

    // action codes
    localparam logic ACT_ENQUEUE = 1'b0;
    localparam logic ACT_DEQUEUE = 1'b1;

    // result status codes
    localparam logic [1:0] ST_ENQUEUED = 2'd0;
    localparam logic [1:0] ST_SERVED   = 2'd1;
    localparam logic [1:0] ST_EMPTY    = 2'd2;
    localparam logic [1:0] ST_FULL     = 2'd3;

    // what one class cell reports to the top level
    typedef struct packed {
        logic full;
        logic take;
    } ptq_cell_stat_t;

endpackage

// ----- rtl/ptq_class_cell.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ptq_class_cell - one priority class of the ticket queue
// Holds a FIFO ring of ticket numbers with head, tail and count. A dequeue
// claim runs down the chain of cells; the first non-empty cell takes it.
// ---------------------------------------------------------------------------
module ptq_class_cell #(
    parameter int DEPTH = ptq_pkg::CLASS_DEPTH_DEF,
    parameter int NUM_W = ptq_pkg::NUMBER_BITS_DEF
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    enq,
    input  logic                    deq,
    input  logic [NUM_W-1:0]        wr_number,
    input  logic                    claim_in,
    output logic                    claim_out,
    output ptq_pkg::ptq_cell_stat_t stat,
    output logic [NUM_W-1:0]        rd_number
);
    import ptq_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [NUM_W-1:0] mem [DEPTH];
    logic [PTR_W-1:0] head_reg, head_next;
    logic [PTR_W-1:0] tail_reg, tail_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [NUM_W-1:0] rd_reg;
    logic             full;
    logic             nonempty;
    logic             do_write;
    logic             do_take;

    assign full      = (count_reg == CNT_W'(DEPTH));
    assign nonempty  = (count_reg != '0);
    assign do_write  = enq && !full;
    assign do_take   = deq && !claim_in && nonempty;
    assign claim_out = claim_in || nonempty;

    always_comb begin
        head_next  = head_reg;
        tail_next  = tail_reg;
        count_next = count_reg;
        if (do_write) begin
            tail_next  = (tail_reg == PTR_W'(DEPTH - 1)) ? '0 : tail_reg + 1'b1;
            count_next = count_reg + 1'b1;
        end else if (do_take) begin
            head_next  = (head_reg == PTR_W'(DEPTH - 1)) ? '0 : head_reg + 1'b1;
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
        end else begin
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_write) begin
            mem[tail_reg] <= wr_number;
        end
        if (do_take) begin
            rd_reg <= mem[head_reg];
        end
    end

    assign stat.full     = full;
    assign stat.take     = do_take;
    assign rd_number     = rd_reg;

endmodule

// ----- rtl/four_class_priority_ticket_queue.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// four_class_priority_ticket_queue - strict priority ticket queue
// Four FIFO class cells (D, G, I, N) in a priority chain; enqueue into a
// class or dequeue the oldest ticket of the highest non-empty class.
//
//   channel  | direction | fields
//   s_*      | in        | action, ticket_category, ticket_number
//   m_*      | out       | status, served_category, served_number
//
// For each item, the accept cycle updates the class cell and registers its
// ring memory read; the output register then loads when empty or taken.
// A stalled result holds the next item in the read stage (s_ready low).
// Reset clears the class pointers and counts; ring contents are not reset.
// ---------------------------------------------------------------------------
module four_class_priority_ticket_queue #(
    parameter int CLASS_DEPTH = ptq_pkg::CLASS_DEPTH_DEF,
    parameter int NUMBER_BITS = ptq_pkg::NUMBER_BITS_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic                                s_action,
    input  logic [ptq_pkg::CLASS_W-1:0]         s_ticket_category,
    input  logic [ptq_pkg::FIELD_NUMBER_W-1:0]  s_ticket_number,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic [1:0]                          m_status,
    output logic [ptq_pkg::CLASS_W-1:0]         m_served_category,
    output logic [ptq_pkg::FIELD_NUMBER_W-1:0]  m_served_number
);
    import ptq_pkg::*;

    logic                  accept;
    logic                  is_enq;
    logic                  is_deq;
    logic [NUM_CLASSES:0]  claim;
    ptq_cell_stat_t        stat [NUM_CLASSES];
    logic [NUMBER_BITS-1:0] rd_number [NUM_CLASSES];
    logic [NUMBER_BITS+FIELD_NUMBER_W-1:0] in_ext;
    logic [NUMBER_BITS-1:0] wr_number;

    logic                  busy_reg, busy_next;
    logic [1:0]            pend_status_reg, pend_status_next;
    logic [CLASS_W-1:0]    pend_cat_reg, pend_cat_next;
    logic [CLASS_W-1:0]    take_idx;
    logic                  any_take;

    logic                  m_valid_reg, m_valid_next;
    logic [1:0]            m_status_reg;
    logic [CLASS_W-1:0]    m_cat_reg;
    logic [FIELD_NUMBER_W-1:0] m_number_reg;
    logic                  load_out;
    logic [NUMBER_BITS+FIELD_NUMBER_W-1:0] out_ext;
    logic [NUMBER_BITS-1:0] sel_number;

    assign s_ready = !busy_reg;
    assign accept  = s_valid && s_ready;
    assign is_enq  = accept && (s_action == ACT_ENQUEUE);
    assign is_deq  = accept && (s_action == ACT_DEQUEUE);

    // keep the low NUMBER_BITS of the ticket number, zero above the field
    assign in_ext    = {{NUMBER_BITS{1'b0}}, s_ticket_number};
    assign wr_number = in_ext[NUMBER_BITS-1:0];

    assign claim[0] = 1'b0;

    for (genvar i = 0; i < NUM_CLASSES; i++) begin : g_cell
        ptq_class_cell #(
            .DEPTH (CLASS_DEPTH),
            .NUM_W (NUMBER_BITS)
        ) u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .enq       (is_enq && (s_ticket_category == CLASS_W'(i))),
            .deq       (is_deq),
            .wr_number (wr_number),
            .claim_in  (claim[i]),
            .claim_out (claim[i+1]),
            .stat      (stat[i]),
            .rd_number (rd_number[i])
        );
    end

    // end of the claim chain: some class holds a ticket
    assign any_take = claim[NUM_CLASSES];

    always_comb begin
        take_idx = '0;
        for (int i = 0; i < NUM_CLASSES; i++) begin
            if (stat[i].take) begin
                take_idx = CLASS_W'(i);
            end
        end
    end

    always_comb begin
        busy_next        = busy_reg;
        pend_status_next = pend_status_reg;
        pend_cat_next    = pend_cat_reg;
        if (accept) begin
            busy_next     = 1'b1;
            pend_cat_next = '0;
            if (s_action == ACT_ENQUEUE) begin
                pend_status_next = stat[s_ticket_category].full ? ST_FULL : ST_ENQUEUED;
            end else if (any_take) begin
                pend_status_next = ST_SERVED;
                pend_cat_next    = take_idx;
            end else begin
                pend_status_next = ST_EMPTY;
            end
        end else if (load_out) begin
            busy_next = 1'b0;
        end
    end

    // result stage: ring read data is ready in the cycle after the transfer
    assign load_out     = busy_reg && (!m_valid_reg || m_ready);
    assign sel_number   = (pend_status_reg == ST_SERVED) ? rd_number[pend_cat_reg] : '0;
    assign out_ext      = {{FIELD_NUMBER_W{1'b0}}, sel_number};
    assign m_valid_next = load_out || (m_valid_reg && !m_ready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            busy_reg    <= busy_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        pend_status_reg <= pend_status_next;
        pend_cat_reg    <= pend_cat_next;
        if (load_out) begin
            m_status_reg <= pend_status_reg;
            m_cat_reg    <= pend_cat_reg;
            m_number_reg <= out_ext[FIELD_NUMBER_W-1:0];
        end
    end

    assign m_valid           = m_valid_reg;
    assign m_status          = m_status_reg;
    assign m_served_category = m_cat_reg;
    assign m_served_number   = m_number_reg;

endmodule

// ----- rtl/ptq_checker.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ptq_checker - port-level checks for the priority ticket queue
// Watches the top level's channels; attached by bind.
// ---------------------------------------------------------------------------
module ptq_checker (
    input logic                                aclk,
    input logic                                aresetn,
    input logic                                s_valid,
    input logic                                s_ready,
    input logic                                m_valid,
    input logic                                m_ready,
    input logic [1:0]                          m_status,
    input logic [ptq_pkg::CLASS_W-1:0]         m_served_category,
    input logic [ptq_pkg::FIELD_NUMBER_W-1:0]  m_served_number
);
    import ptq_pkg::*;

    // no result survives reset
    a_reset_clears: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("m_valid high after reset");

    // one item in flight: an input transfer closes the input side
    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("input taken while an item is in flight");

    // a new result only appears after an item was held in the read stage
    a_result_from_item: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> !$past(s_ready))
        else $error("result without an accepted item");

    // only a served ticket carries a category and number
    a_unserved_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && (m_status != ST_SERVED)) |->
            (m_served_category == '0) && (m_served_number == '0))
        else $error("nonzero ticket on a result without a served ticket");

    // stalled result holds
    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=>
            m_valid && $stable(m_status) && $stable(m_served_category)
            && $stable(m_served_number))
        else $error("result changed while stalled");

endmodule

bind four_class_priority_ticket_queue ptq_checker u_ptq_checker (
    .aclk              (aclk),
    .aresetn           (aresetn),
    .s_valid           (s_valid),
    .s_ready           (s_ready),
    .m_valid           (m_valid),
    .m_ready           (m_ready),
    .m_status          (m_status),
    .m_served_category (m_served_category),
    .m_served_number   (m_served_number)
);
